// File: src/frgbe_pkg.sv
// package for the float to rgbe encoder: widths, constants and stage types
// no dependencies
`default_nettype none
package frgbe_pkg;
   localparam logic [63:0] BlackThreshold = 64'h3E112E0BE826D695;
   localparam logic [10:0] OverflowExp = 11'd1150;
   localparam logic [10:0] ExpOffset = 11'd1022;
   localparam logic [10:0] ExpBias = 11'd128;
   localparam logic [10:0] ShiftBase = 11'd45;
   localparam logic [10:0] ShiftLimit = 11'd64;

   typedef struct packed {
      logic [63:0] comp0;
      logic [63:0] comp1;
      logic [63:0] comp2;
   } pixel_type;

   typedef struct packed {
      logic black;
      logic over;
      logic [10:0] big_exp;
   } flags_type;

   function automatic logic [63:0] clamp_bits(input logic [63:0] b);
      logic [63:0] r;
      r = b;
      if (b[63]) r = '0;
      else if (b[62:52] == 11'h7FF && b[51:0] != '0) r = '0;
      return r;
   endfunction

   function automatic logic [7:0] mant_byte(input logic [63:0] c, input logic [10:0] bl);
      logic [10:0] ec;
      logic [52:0] sig;
      logic [10:0] sh;
      logic [52:0] shifted;
      ec = c[62:52];
      sig = {1'b1, c[51:0]};
      if (ec == '0) begin
         ec = 11'd1;
         sig = {1'b0, c[51:0]};
      end
      sh = bl - ec + ShiftBase;
      shifted = sig >> sh[5:0];
      if (ec > bl) return 8'hFF;
      if (sh >= ShiftLimit) return 8'h00;
      return shifted[7:0];
   endfunction
endpackage
`default_nettype wire

// File: src/frgbe_max.sv
// stages one and two: clamp components, then pick largest and classify
// depends on frgbe_pkg
`default_nettype none
module frgbe_max
   import frgbe_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      adv,
   input  wire logic      in_valid,
   input  pixel_type      in_pix,
   output logic           out_valid,
   output pixel_type      out_pix,
   output flags_type      out_flags
);
   logic v1_ff, v2_ff;
   pixel_type p1_ff, p2_ff;
   logic [63:0] big_in;
   flags_type f_in, f_ff;

   always_comb begin
      big_in = p1_ff.comp0;
      if (p1_ff.comp1 > big_in) big_in = p1_ff.comp1;
      if (p1_ff.comp2 > big_in) big_in = p1_ff.comp2;
      f_in.black = big_in < BlackThreshold;
      f_in.over = big_in[62:52] >= OverflowExp;
      f_in.big_exp = big_in[62:52];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (adv) begin
         p1_ff.comp0 <= clamp_bits(in_pix.comp0);
         p1_ff.comp1 <= clamp_bits(in_pix.comp1);
         p1_ff.comp2 <= clamp_bits(in_pix.comp2);
         p2_ff <= p1_ff;
         f_ff <= f_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_pix = p2_ff;
   assign out_flags = f_ff;
endmodule
`default_nettype wire

// File: src/frgbe_scale.sv
// stage three: shift each component to the shared exponent and form the word
// depends on frgbe_pkg
`default_nettype none
module frgbe_scale
   import frgbe_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   adv,
   input  wire logic   in_valid,
   input  pixel_type   in_pix,
   input  flags_type   in_flags,
   output logic        out_valid,
   output logic [31:0] out_word
);
   logic v_ff;
   logic [31:0] w_ff, w_in;
   logic [10:0] e_sum;

   always_comb begin
      e_sum = in_flags.big_exp - ExpOffset + ExpBias;
      if (in_flags.black) w_in = '0;
      else if (in_flags.over) w_in = '1;
      else w_in = {e_sum[7:0], mant_byte(in_pix.comp2, in_flags.big_exp),
                   mant_byte(in_pix.comp1, in_flags.big_exp),
                   mant_byte(in_pix.comp0, in_flags.big_exp)};
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (adv) v_ff <= in_valid;
      if (adv) w_ff <= w_in;
   end

   assign out_valid = v_ff;
   assign out_word = w_ff;
endmodule
`default_nettype wire

// File: src/float_to_rgbe_encode.sv
// float to rgbe encoder top level: three-stage pipeline of frgbe_max and frgbe_scale
// depends on frgbe_pkg, frgbe_max, frgbe_scale
//
// usage: one pixel item per cycle on req_ (three binary64 components in
// req_tdata), one rgbe word item per cycle on rsp_, while rsp_tready is high.
// req_ acceptance reaches rsp_tvalid through three register stages (clamp,
// largest and classify, scale); throughput is one item per cycle unless the
// receiver stalls.
// the pipeline advances whenever its last stage is empty or rsp_tready is
// high; when the receiver stalls every stage holds and req_tready falls
// only if the output stage holds a result.
// reset clears all valid bits; no item is in flight afterward.
// a black pixel gives an all-zero word, an overflow gives all 255.
`default_nettype none
module float_to_rgbe_encode
   import frgbe_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [191:0] req_tdata,  // red_value, green_value, blue_value
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata   // red_mantissa, green_mantissa, blue_mantissa, shared_exponent
);
   logic adv, v2;
   pixel_type pix_in, pix2;
   flags_type flags2;

   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign pix_in.comp0 = req_tdata[63:0];
   assign pix_in.comp1 = req_tdata[127:64];
   assign pix_in.comp2 = req_tdata[191:128];

   frgbe_max u_max (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(req_tvalid),
      .in_pix(pix_in), .out_valid(v2), .out_pix(pix2), .out_flags(flags2)
   );

   frgbe_scale u_scale (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(v2), .in_pix(pix2),
      .in_flags(flags2), .out_valid(rsp_tvalid), .out_word(rsp_tdata)
   );
endmodule
`default_nettype wire

// File: src/frgbe_checker.sv
// port-level checker for float_to_rgbe_encode, bound to the top level
// depends on float_to_rgbe_encode ports only
`default_nettype none
module frgbe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);
   a_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready) else $error("ready low");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("rsp hold");
   a_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[31:24] == 8'd0) |-> rsp_tdata[23:0] == 24'd0)
      else $error("black word");
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_tvalid, req_tready, rsp_tvalid}))
      else $error("handshake unknown");
   a_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown(rsp_tdata))
      else $error("rsp data unknown");
endmodule

bind float_to_rgbe_encode frgbe_checker u_frgbe_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire

// File: tb/sv/float_to_rgbe_encode_test.sv
// testbench for float_to_rgbe_encode: directed and random pixels, shared-exponent
// words checked against an independent predictor; depends on frgbe_pkg and the block
`default_nettype none
module float_to_rgbe_encode_test;
   import frgbe_pkg::*;

   localparam int MaxQuiet = 20000;
   localparam logic [63:0] PosInf = 64'h7FF0000000000000;
   localparam logic [63:0] OneVal = 64'h3FF0000000000000;

   class rgbe_scoreboard;
      logic [31:0] words_due[$];
      int mismatches;

      function logic [63:0] sanitize(logic [63:0] b);
         if (b[63] || (b[62:52] == 11'h7FF && b[51:0] != 0)) return 64'd0;
         return b;
      endfunction

      function logic [7:0] scaled_byte(logic [63:0] c, int unsigned top_exp);
         int unsigned ce, sh;
         logic [52:0] sig;
         ce = {21'd0, c[62:52]};
         sig = {1'b1, c[51:0]};
         if (ce == 0) begin
            ce = 1;
            sig = {1'b0, c[51:0]};
         end
         sh = top_exp - ce + 45;
         if (sh >= 64) return 8'h00;
         return 8'(sig >> sh);
      endfunction

      function logic [31:0] encode(logic [191:0] px);
         logic [63:0] c[3];
         logic [63:0] top;
         int unsigned te;
         for (int i = 0; i < 3; i++) c[i] = sanitize(px[64*i +: 64]);
         top = c[0];
         if (c[1] > top) top = c[1];
         if (c[2] > top) top = c[2];
         if (top < 64'h3E112E0BE826D695) return 32'h0;
         te = {21'd0, top[62:52]};
         if (te >= 1150) return 32'hFFFFFFFF;
         return {8'(te - 1022 + 128), scaled_byte(c[2], te), scaled_byte(c[1], te),
                 scaled_byte(c[0], te)};
      endfunction

      function void note_pixel(logic [191:0] px);
         words_due.push_back(encode(px));
      endfunction

      function void check_word(logic [31:0] got);
         logic [31:0] want;
         if (words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %h", got);
            return;
         end
         want = words_due.pop_front();
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [191:0] req_tdata;
   logic [31:0] rsp_tdata;
   int send_idle, recv_stall, quiet;
   rgbe_scoreboard board;

   float_to_rgbe_encode dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      board = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      rsp_tready = 0;
      send_idle = 0;
      recv_stall = 0;
      quiet = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         rsp_tready <= ($urandom_range(99) >= recv_stall);
         if (rsp_tvalid && rsp_tready) board.check_word(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
         else quiet <= quiet + 1;
         if (quiet >= MaxQuiet) begin
            $display("FAIL float_to_rgbe_encode");
            $finish;
         end
      end
   end

   function automatic logic [63:0] rand_comp();
      logic [63:0] v;
      int unsigned k;
      v = {$urandom, $urandom};
      k = $urandom_range(9);
      case (k)
         0, 1, 2: v[62:52] = 11'($urandom_range(1150, 990));
         3: v[62:52] = 11'($urandom_range(1030, 1010));
         4: v[62:52] = 11'h7FF;
         5: v[62:52] = 11'($urandom_range(4));
         6: v[62:52] = 11'($urandom_range(1150, 1140));
         default: v[62:52] = 11'($urandom_range(1022, 960));
      endcase
      if (k != 4 && $urandom_range(3) != 0) v[63] = 0;
      if (k == 4 && $urandom_range(1)) v[51:0] = 0;
      return v;
   endfunction

   task automatic send_pixel(logic [63:0] r, logic [63:0] g, logic [63:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {b, g, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_pixel({b, g, r});
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.words_due.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [63:0] edge_vals[12];
      edge_vals = '{64'd0, 64'h8000000000000000, PosInf, 64'hFFF0000000000000,
                    64'h7FF8000000000001, 64'h0000000000000001, 64'h000FFFFFFFFFFFFF,
                    64'h3E112E0BE826D695, 64'h3E112E0BE826D694, 64'h47DFFFFFFFFFFFFF,
                    64'h47E0000000000000, 64'h7FEFFFFFFFFFFFFF};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (edge_vals[i]) send_pixel(edge_vals[i], OneVal, 64'd0);
      foreach (edge_vals[i]) send_pixel(64'd0, 64'h3FE0000000000000, edge_vals[i]);
      send_pixel(64'h3FEFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 64'h0000000000000001);
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 84; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 84; end
            default: begin send_idle = 6; recv_stall = 6; end
         endcase
         for (int n = 0; n < 160; n++) send_pixel(rand_comp(), rand_comp(), rand_comp());
         drain();
      end
      send_idle = 0;
      recv_stall = 0;
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.words_due.size() == 0)
         $display("PASS float_to_rgbe_encode");
      else
         $display("FAIL float_to_rgbe_encode");
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
src/frgbe_pkg.sv
src/frgbe_max.sv
src/frgbe_scale.sv
src/float_to_rgbe_encode.sv
src/frgbe_checker.sv
tb/sv/float_to_rgbe_encode_test.sv
